/* hw/rtl/gated_instruction_counter_top_defines.svh */
// assertion macros for the gated instruction counter
// used by gated_instruction_counter_top; needs clk and rst_n in scope
`ifndef GATED_INSTRUCTION_COUNTER_TOP_DEFINES_SVH
`define GATED_INSTRUCTION_COUNTER_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define GIC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define GIC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/gic_pkg.sv */
// shared widths, constants and types of the gated instruction counter
// no dependencies
package gic_pkg;

  localparam int unsigned ADDR_W    = 64;
  localparam int unsigned INSN_W    = 10;
  localparam int unsigned CNT_W     = 64;
  localparam int unsigned SEG_IDX_W = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_W     = 64;

  // largest instruction count added per block
  localparam logic [INSN_W-1:0] MAX_BLOCK_INSNS = 10'd512;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_ENABLE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LOW     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_HIGH    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GATE_ENABLE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OPEN_ADDRESS  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_ADDRESS = 3'd5;

  // how the back end treats a block
  typedef enum logic [1:0] {
    KIND_UNGATED = 2'd0,
    KIND_PLAIN   = 2'd1,
    KIND_OPEN    = 2'd2,
    KIND_CLOSE   = 2'd3
  } gic_kind_t;

  // classified item passed through the queue
  typedef struct packed {
    gic_kind_t           kind;
    logic                range_hit;
    logic [INSN_W-1:0]   insn_count;
  } gic_item_t;

  // queue fill status
  typedef struct packed {
    logic full;
    logic empty;
  } gic_q_status_t;

endpackage

/* hw/rtl/gic_front.sv */
// front end: configuration registers, input stage, clamp and classification
// depends on gic_pkg
module gic_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [gic_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gic_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [gic_pkg::ADDR_W-1:0]    in_block_address,
  input  logic [gic_pkg::INSN_W-1:0]    in_block_insn_count,
  input  gic_pkg::gic_q_status_t        q_stat,
  output logic                          push,
  output gic_pkg::gic_item_t            push_item
);
  import gic_pkg::*;

  logic              range_enable_r;
  logic [ADDR_W-1:0] range_low_r;
  logic [ADDR_W-1:0] range_high_r;
  logic              gate_enable_r;
  logic [ADDR_W-1:0] open_marker_r;
  logic [ADDR_W-1:0] close_marker_r;

  logic              stage_valid_r;
  logic              stage_valid_nxt;
  gic_item_t         stage_item_r;
  gic_item_t         stage_item_nxt;
  logic              take;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_enable_r <= 1'b0;
      range_low_r    <= '0;
      range_high_r   <= '0;
      gate_enable_r  <= 1'b0;
      open_marker_r  <= '0;
      close_marker_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RANGE_ENABLE:  range_enable_r <= cfg_wdata[0];
        CFG_RANGE_LOW:     range_low_r    <= cfg_wdata[ADDR_W-1:0];
        CFG_RANGE_HIGH:    range_high_r   <= cfg_wdata[ADDR_W-1:0];
        CFG_GATE_ENABLE:   gate_enable_r  <= cfg_wdata[0];
        CFG_OPEN_ADDRESS:  open_marker_r  <= cfg_wdata[ADDR_W-1:0];
        CFG_CLOSE_ADDRESS: close_marker_r <= cfg_wdata[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  // stage moves on when empty or when its item enters the queue
  assign push     = stage_valid_r && !q_stat.full;
  assign in_ready = !stage_valid_r || push;
  assign take     = in_valid && in_ready;

  // clamp and classify the incoming item
  always_comb begin
    stage_item_nxt = stage_item_r;
    if (in_block_insn_count > MAX_BLOCK_INSNS) begin
      stage_item_nxt.insn_count = MAX_BLOCK_INSNS;
    end else begin
      stage_item_nxt.insn_count = in_block_insn_count;
    end
    stage_item_nxt.range_hit = range_enable_r &&
                               (in_block_address >= range_low_r) &&
                               (in_block_address < range_high_r);
    // open wins when both marker addresses match
    if (!gate_enable_r) begin
      stage_item_nxt.kind = KIND_UNGATED;
    end else if (in_block_address == open_marker_r) begin
      stage_item_nxt.kind = KIND_OPEN;
    end else if (in_block_address == close_marker_r) begin
      stage_item_nxt.kind = KIND_CLOSE;
    end else begin
      stage_item_nxt.kind = KIND_PLAIN;
    end
  end

  // stage valid
  always_comb begin
    stage_valid_nxt = stage_valid_r;
    if (take) begin
      stage_valid_nxt = 1'b1;
    end else if (push) begin
      stage_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else begin
      stage_valid_r <= stage_valid_nxt;
    end
  end

  // payload holds no reset
  always_ff @(posedge clk) begin
    if (take) begin
      stage_item_r <= stage_item_nxt;
    end
  end

  assign push_item = stage_item_r;

endmodule

/* hw/rtl/gic_queue.sv */
// short queue of classified items between front and back end
// depends on gic_pkg
module gic_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  gic_pkg::gic_item_t     push_item,
  input  logic                   pop,
  output gic_pkg::gic_item_t     pop_item,
  output gic_pkg::gic_q_status_t q_stat
);
  import gic_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_QW = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0]  LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_QW-1:0] FULL_CNT = CNT_QW'(DEPTH);

  gic_item_t          mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_nxt;
  logic [CNT_QW-1:0]  count_r;
  logic [CNT_QW-1:0]  count_nxt;

  // storage write
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

  assign pop_item = mem[rd_ptr_r];

  // pointers wrap at the depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  assign q_stat.full  = (count_r == FULL_CNT);
  assign q_stat.empty = (count_r == '0);

endmodule

/* hw/rtl/gic_back.sv */
// back end: counters, gate state and the output register
// depends on gic_pkg
module gic_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  gic_pkg::gic_q_status_t        q_stat,
  input  gic_pkg::gic_item_t            pop_item,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [gic_pkg::CNT_W-1:0]     out_total_count,
  output logic [gic_pkg::CNT_W-1:0]     out_range_count,
  output logic [gic_pkg::CNT_W-1:0]     out_gated_total,
  output logic [gic_pkg::CNT_W-1:0]     out_segment_running,
  output logic                          out_gate_is_open,
  output logic [gic_pkg::CNT_W-1:0]     out_open_events,
  output logic [gic_pkg::CNT_W-1:0]     out_close_events,
  output logic                          out_segment_done,
  output logic [gic_pkg::SEG_IDX_W-1:0] out_segment_index,
  output logic [gic_pkg::CNT_W-1:0]     out_segment_value
);
  import gic_pkg::*;

  logic                 out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0]     total_r, total_nxt;
  logic [CNT_W-1:0]     range_r, range_nxt;
  logic [CNT_W-1:0]     gated_r, gated_nxt;
  logic [CNT_W-1:0]     seg_r, seg_nxt;
  logic                 gate_flag_r, gate_flag_nxt;
  logic [CNT_W-1:0]     opens_r, opens_nxt;
  logic [CNT_W-1:0]     closes_r, closes_nxt;
  logic [SEG_IDX_W-1:0] seg_closed_r, seg_closed_nxt;
  logic                 done_r, done_nxt;
  logic [SEG_IDX_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0]     val_r, val_nxt;
  logic [CNT_W-1:0]     n_ext;

  // a new item is taken once the previous result has left
  assign pop   = !q_stat.empty && (!out_valid_r || out_ready);
  assign n_ext = {{(CNT_W-INSN_W){1'b0}}, pop_item.insn_count};

  // counter updates for one item
  always_comb begin
    total_nxt      = total_r + n_ext;
    range_nxt      = pop_item.range_hit ? range_r + n_ext : range_r;
    gated_nxt      = gated_r;
    seg_nxt        = seg_r;
    gate_flag_nxt  = gate_flag_r;
    opens_nxt      = opens_r;
    closes_nxt     = closes_r;
    seg_closed_nxt = seg_closed_r;
    done_nxt       = 1'b0;
    idx_nxt        = '0;
    val_nxt        = '0;
    unique case (pop_item.kind)
      KIND_OPEN: begin
        seg_nxt       = '0;
        gate_flag_nxt = 1'b1;
        opens_nxt     = opens_r + 1'b1;
      end
      KIND_CLOSE: begin
        gate_flag_nxt = 1'b0;
        done_nxt      = 1'b1;
        idx_nxt       = seg_closed_r;
        val_nxt       = seg_r;
        gated_nxt     = gated_r + seg_r;
        closes_nxt    = closes_r + 1'b1;
        // index saturates at all ones
        if (seg_closed_r != '1) begin
          seg_closed_nxt = seg_closed_r + 1'b1;
        end
      end
      KIND_PLAIN: begin
        if (gate_flag_r) begin
          seg_nxt = seg_r + n_ext;
        end
      end
      default: ;
    endcase
  end

  // output valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // counters double as the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      total_r      <= '0;
      range_r      <= '0;
      gated_r      <= '0;
      seg_r        <= '0;
      gate_flag_r  <= 1'b0;
      opens_r      <= '0;
      closes_r     <= '0;
      seg_closed_r <= '0;
      done_r       <= 1'b0;
      idx_r        <= '0;
      val_r        <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        total_r      <= total_nxt;
        range_r      <= range_nxt;
        gated_r      <= gated_nxt;
        seg_r        <= seg_nxt;
        gate_flag_r  <= gate_flag_nxt;
        opens_r      <= opens_nxt;
        closes_r     <= closes_nxt;
        seg_closed_r <= seg_closed_nxt;
        done_r       <= done_nxt;
        idx_r        <= idx_nxt;
        val_r        <= val_nxt;
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_total_count     = total_r;
  assign out_range_count     = range_r;
  assign out_gated_total     = gated_r;
  assign out_segment_running = seg_r;
  assign out_gate_is_open    = gate_flag_r;
  assign out_open_events     = opens_r;
  assign out_close_events    = closes_r;
  assign out_segment_done    = done_r;
  assign out_segment_index   = idx_r;
  assign out_segment_value   = val_r;

endmodule

/* hw/rtl/gated_instruction_counter_top.sv */
// channel   | handshake           | payload
// ----------+---------------------+-----------------------------------------
// input     | in_valid/in_ready   | in_block_address, in_block_insn_count
// result    | out_valid/out_ready | out_total_count ... out_segment_value
// config    | cfg_we (no wait)    | cfg_index, cfg_wdata
//
// one item per cycle sustained while the result side does not stall; an accepted item passes
// the input stage, then the queue, then the counter update before its result is valid.
// synchronous active-low reset clears the counters, gate and configuration.
// either side may stall; the queue of QUEUE_DEPTH items absorbs the gap.
//
// top level of the gated instruction counter
// depends on gic_pkg, gic_front, gic_queue, gic_back and the defines header
`include "gated_instruction_counter_top_defines.svh"

module gated_instruction_counter_top #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [gic_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gic_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [gic_pkg::ADDR_W-1:0]    in_block_address,
  input  logic [gic_pkg::INSN_W-1:0]    in_block_insn_count,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [gic_pkg::CNT_W-1:0]     out_total_count,
  output logic [gic_pkg::CNT_W-1:0]     out_range_count,
  output logic [gic_pkg::CNT_W-1:0]     out_gated_total,
  output logic [gic_pkg::CNT_W-1:0]     out_segment_running,
  output logic                          out_gate_is_open,
  output logic [gic_pkg::CNT_W-1:0]     out_open_events,
  output logic [gic_pkg::CNT_W-1:0]     out_close_events,
  output logic                          out_segment_done,
  output logic [gic_pkg::SEG_IDX_W-1:0] out_segment_index,
  output logic [gic_pkg::CNT_W-1:0]     out_segment_value
);
  import gic_pkg::*;

  gic_q_status_t q_stat;
  gic_item_t     push_item;
  gic_item_t     pop_item;
  logic          push;
  logic          pop;
  logic          close_popped;
  logic          close_shown;
  logic          plain_shown;
  logic          seg_fields_zero;

  // classify incoming items
  gic_front u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_block_address    (in_block_address),
    .in_block_insn_count (in_block_insn_count),
    .q_stat              (q_stat),
    .push                (push),
    .push_item           (push_item)
  );

  // decoupling queue
  gic_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .q_stat    (q_stat)
  );

  // counters and result
  gic_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_stat              (q_stat),
    .pop_item            (pop_item),
    .pop                 (pop),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_total_count     (out_total_count),
    .out_range_count     (out_range_count),
    .out_gated_total     (out_gated_total),
    .out_segment_running (out_segment_running),
    .out_gate_is_open    (out_gate_is_open),
    .out_open_events     (out_open_events),
    .out_close_events    (out_close_events),
    .out_segment_done    (out_segment_done),
    .out_segment_index   (out_segment_index),
    .out_segment_value   (out_segment_value)
  );

  // terms used by the checks
  assign close_popped    = pop && (pop_item.kind == KIND_CLOSE);
  assign close_shown     = out_valid && out_segment_done;
  assign plain_shown     = out_valid && !out_segment_done;
  assign seg_fields_zero = (out_segment_value == '0) && (out_segment_index == '0);

  // checks
  `GIC_ASSERT_NOW(a_no_push_when_full, push, !q_stat.full, "push into full queue")
  `GIC_ASSERT_NEXT(a_close_done, close_popped, close_shown, "close item lost its segment")
  `GIC_ASSERT_NOW(a_done_closes_gate, close_shown, !out_gate_is_open, "gate open after close")
  `GIC_ASSERT_NOW(a_idle_segment_zero, plain_shown, seg_fields_zero, "segment set without close")

endmodule

/* dv/gated_instruction_counter_checker.sv */
// checker for the gated instruction counter: predicts one result per item and compares
// watches the config, input and result channels; depends on gic_pkg
module gated_instruction_counter_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [gic_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gic_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [gic_pkg::ADDR_W-1:0]    in_block_address,
  input  logic [gic_pkg::INSN_W-1:0]    in_block_insn_count,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [gic_pkg::CNT_W-1:0]     out_total_count,
  input  logic [gic_pkg::CNT_W-1:0]     out_range_count,
  input  logic [gic_pkg::CNT_W-1:0]     out_gated_total,
  input  logic [gic_pkg::CNT_W-1:0]     out_segment_running,
  input  logic                          out_gate_is_open,
  input  logic [gic_pkg::CNT_W-1:0]     out_open_events,
  input  logic [gic_pkg::CNT_W-1:0]     out_close_events,
  input  logic                          out_segment_done,
  input  logic [gic_pkg::SEG_IDX_W-1:0] out_segment_index,
  input  logic [gic_pkg::CNT_W-1:0]     out_segment_value,
  output int unsigned                   mismatch_count,
  output int unsigned                   results_owed
);
  timeunit 1ns;
  timeprecision 1ps;
  import gic_pkg::*;

  // counter values reported for one item
  typedef struct packed {
    logic [CNT_W-1:0]     total;
    logic [CNT_W-1:0]     in_range;
    logic [CNT_W-1:0]     gated;
    logic [CNT_W-1:0]     segment;
    logic                 gate_flag;
    logic [CNT_W-1:0]     opens;
    logic [CNT_W-1:0]     closes;
    logic                 seg_done;
    logic [SEG_IDX_W-1:0] seg_index;
    logic [CNT_W-1:0]     seg_value;
  } counter_snapshot_t;

  // settings as last written
  logic              range_on;
  logic [ADDR_W-1:0] range_lo;
  logic [ADDR_W-1:0] range_hi;
  logic              gate_on;
  logic [ADDR_W-1:0] open_at;
  logic [ADDR_W-1:0] close_at;

  // predicted counter state
  logic [CNT_W-1:0]     total_sum;
  logic [CNT_W-1:0]     range_sum;
  logic [CNT_W-1:0]     gated_sum;
  logic [CNT_W-1:0]     segment_sum;
  logic                 gate_state;
  logic [CNT_W-1:0]     open_tally;
  logic [CNT_W-1:0]     close_tally;
  logic [SEG_IDX_W-1:0] closed_segments;

  counter_snapshot_t expected_counts[$];
  int unsigned       errors;

  function automatic gic_kind_t classify_block(logic [ADDR_W-1:0] addr);
    if (!gate_on) return KIND_UNGATED;
    // open wins when both markers share an address
    if (addr == open_at) return KIND_OPEN;
    if (addr == close_at) return KIND_CLOSE;
    return KIND_PLAIN;
  endfunction

  // advance the counters by one executed block
  task automatic count_block(input logic [ADDR_W-1:0] addr, input logic [INSN_W-1:0] raw,
                             output counter_snapshot_t snap);
    logic [CNT_W-1:0] n;
    n = (raw > MAX_BLOCK_INSNS) ? CNT_W'(MAX_BLOCK_INSNS) : CNT_W'(raw);
    snap = '0;
    total_sum = total_sum + n;
    if (range_on && addr >= range_lo && addr < range_hi) range_sum = range_sum + n;
    case (classify_block(addr))
      KIND_OPEN: begin
        segment_sum = '0;
        gate_state  = 1'b1;
        open_tally  = open_tally + 1;
      end
      KIND_CLOSE: begin
        gate_state     = 1'b0;
        snap.seg_done  = 1'b1;
        snap.seg_index = closed_segments;
        snap.seg_value = segment_sum;
        if (closed_segments != '1) closed_segments = closed_segments + 1;
        gated_sum   = gated_sum + segment_sum;
        close_tally = close_tally + 1;
      end
      KIND_PLAIN: begin
        if (gate_state) segment_sum = segment_sum + n;
      end
      default: ;
    endcase
    snap.total     = total_sum;
    snap.in_range  = range_sum;
    snap.gated     = gated_sum;
    snap.segment   = segment_sum;
    snap.gate_flag = gate_state;
    snap.opens     = open_tally;
    snap.closes    = close_tally;
  endtask

  task automatic check_field(input string name, input logic [63:0] want_v,
                             input logic [63:0] got_v);
    if (got_v !== want_v) begin
      errors++;
      if (errors <= 10) $display("mismatch on %s: expected %0h, got %0h", name, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    counter_snapshot_t want;
    counter_snapshot_t fresh;
    if (!rst_n) begin
      range_on        = 1'b0;
      range_lo        = '0;
      range_hi        = '0;
      gate_on         = 1'b0;
      open_at         = '0;
      close_at        = '0;
      total_sum       = '0;
      range_sum       = '0;
      gated_sum       = '0;
      segment_sum     = '0;
      gate_state      = 1'b0;
      open_tally      = '0;
      close_tally     = '0;
      closed_segments = '0;
      errors          = 0;
      expected_counts.delete();
    end else begin
      // register writes, one-bit registers keep bit 0
      if (cfg_we) begin
        case (cfg_index)
          CFG_RANGE_ENABLE:  range_on = cfg_wdata[0];
          CFG_RANGE_LOW:     range_lo = cfg_wdata;
          CFG_RANGE_HIGH:    range_hi = cfg_wdata;
          CFG_GATE_ENABLE:   gate_on  = cfg_wdata[0];
          CFG_OPEN_ADDRESS:  open_at  = cfg_wdata;
          CFG_CLOSE_ADDRESS: close_at = cfg_wdata;
          default: ;
        endcase
      end
      // compare each result with the oldest prediction
      if (out_valid && out_ready) begin
        if (expected_counts.size() == 0) begin
          errors++;
          if (errors <= 10) $display("result with no item outstanding: total %0h",
                                     out_total_count);
        end else begin
          want = expected_counts.pop_front();
          check_field("total_count", want.total, out_total_count);
          check_field("range_count", want.in_range, out_range_count);
          check_field("gated_total", want.gated, out_gated_total);
          check_field("segment_running", want.segment, out_segment_running);
          check_field("gate_is_open", want.gate_flag, out_gate_is_open);
          check_field("open_events", want.opens, out_open_events);
          check_field("close_events", want.closes, out_close_events);
          check_field("segment_done", want.seg_done, out_segment_done);
          check_field("segment_index", want.seg_index, out_segment_index);
          check_field("segment_value", want.seg_value, out_segment_value);
        end
      end
      // predict the result of each accepted item
      if (in_valid && in_ready) begin
        count_block(in_block_address, in_block_insn_count, fresh);
        expected_counts.push_back(fresh);
      end
    end
    mismatch_count <= errors;
    results_owed   <= expected_counts.size();
  end

endmodule

/* dv/gated_instruction_counter_top_test.sv */
// testbench top for gated_instruction_counter_top: clock, reset, stimulus and verdict
// depends on gic_pkg, the block and gated_instruction_counter_checker
module gated_instruction_counter_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import gic_pkg::*;

  localparam int unsigned IDLE_PCT        = 30;
  localparam int unsigned HOLD_CYCLES     = 150;
  localparam int unsigned STALL_LIMIT     = 2000;
  localparam int unsigned DRAIN_CYCLES    = 8;
  localparam int unsigned RANDOM_PHASES   = 5;
  localparam int unsigned ITEMS_PER_PHASE = 110;

  // indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [ADDR_W-1:0]    in_block_address = '0;
  logic [INSN_W-1:0]    in_block_insn_count = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [CNT_W-1:0]     out_total_count;
  logic [CNT_W-1:0]     out_range_count;
  logic [CNT_W-1:0]     out_gated_total;
  logic [CNT_W-1:0]     out_segment_running;
  logic                 out_gate_is_open;
  logic [CNT_W-1:0]     out_open_events;
  logic [CNT_W-1:0]     out_close_events;
  logic                 out_segment_done;
  logic [SEG_IDX_W-1:0] out_segment_index;
  logic [CNT_W-1:0]     out_segment_value;
  int unsigned          mismatch_count;
  int unsigned          results_owed;

  // stimulus-side copy of the addresses in use
  logic [ADDR_W-1:0] set_lo;
  logic [ADDR_W-1:0] set_hi;
  logic [ADDR_W-1:0] set_open;
  logic [ADDR_W-1:0] set_close;

  bit          no_idle  = 1'b0;
  bit          hold_req = 1'b0;
  bit          spare_pick = 1'b0;
  int unsigned stall_cycles = 0;

  gated_instruction_counter_top u_top (.*);

  gated_instruction_counter_checker u_checker (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // end the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_valid && in_ready) || (out_valid && out_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("gated_instruction_counter_top test failed");
      $finish;
    end
  end

  // result side: random stalls, steady stretches and one long hold-off
  initial begin
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        out_ready <= 1'b1;
      end else begin
        out_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // mostly legal counts, now and then an oversized one
  function automatic logic [INSN_W-1:0] pick_count();
    if ($urandom_range(0, 9) == 0) return INSN_W'($urandom_range(513, 1023));
    return INSN_W'($urandom_range(0, 512));
  endfunction

  // addresses around the range edges, offsets above the low edge, plus fully random ones
  function logic [ADDR_W-1:0] pick_plain();
    case ($urandom_range(0, 5))
      0:       return set_lo;
      1:       return set_lo - 1;
      2:       return set_hi - 1;
      3:       return set_hi;
      4:       return set_lo + ADDR_W'($urandom_range(0, 4095));
      default: return rand_word();
    endcase
  endfunction

  task automatic send_block(input logic [ADDR_W-1:0] addr, input logic [INSN_W-1:0] cnt);
    if (!no_idle) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid            <= 1'b1;
    in_block_address    <= addr;
    in_block_insn_count <= cnt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // stop offering and wait for every outstanding result
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // program all registers, then poke an unused index
  task automatic apply_setting(input logic [CFG_W-1:0] range_en, input logic [CFG_W-1:0] lo,
                               input logic [CFG_W-1:0] hi, input logic [CFG_W-1:0] gate_en,
                               input logic [CFG_W-1:0] open_addr,
                               input logic [CFG_W-1:0] close_addr);
    wait_idle();
    write_reg(CFG_RANGE_ENABLE, range_en);
    write_reg(CFG_RANGE_LOW, lo);
    write_reg(CFG_RANGE_HIGH, hi);
    write_reg(CFG_GATE_ENABLE, gate_en);
    write_reg(CFG_OPEN_ADDRESS, open_addr);
    write_reg(CFG_CLOSE_ADDRESS, close_addr);
    write_reg(spare_pick ? CFG_SPARE_B : CFG_SPARE_A, rand_word());
    spare_pick = !spare_pick;
    cfg_we    <= 1'b0;
    set_lo    = lo;
    set_hi    = hi;
    set_open  = open_addr;
    set_close = close_addr;
  endtask

  // mostly open..plain..close segments with random content, the rest noise
  task automatic run_random_phase(input int phase);
    logic [ADDR_W-1:0] lo_pick;
    logic [ADDR_W-1:0] hi_pick;
    logic [ADDR_W-1:0] swap;
    int                left;
    int                k;
    case (phase)
      0: apply_setting(64'h1, '0, '1, 64'h1, '0, '1);
      1: apply_setting(rand_word() | 64'h1, '1, '0, rand_word() | 64'h1, '1, '0);
      default: begin
        lo_pick = rand_word();
        hi_pick = lo_pick + ADDR_W'($urandom_range(0, 4096));
        if ($urandom_range(0, 3) == 0) begin
          swap    = lo_pick;
          lo_pick = hi_pick;
          hi_pick = swap;
        end
        apply_setting(rand_word(), lo_pick, hi_pick,
                      (phase == 3) ? (rand_word() & ~64'h1) : (rand_word() | 64'h1),
                      rand_word(), rand_word());
      end
    endcase
    no_idle = (phase == 1);
    if (phase == 2) hold_req = 1'b1;
    left = ITEMS_PER_PHASE;
    while (left > 0) begin
      if ($urandom_range(0, 9) < 7) begin
        k = $urandom_range(0, 6);
        send_block(set_open, pick_count());
        repeat (k) send_block(pick_plain(), pick_count());
        send_block(set_close, pick_count());
        left -= k + 2;
      end else begin
        case ($urandom_range(0, 2))
          0:       send_block(set_open, pick_count());
          1:       send_block(set_close, pick_count());
          default: send_block(rand_word(), pick_count());
        endcase
        left--;
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    set_lo    = '0;
    set_hi    = '0;
    set_open  = '0;
    set_close = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: gating off, so address zero is an ordinary block
    send_block('0, 10'd0);
    send_block('1, 10'd1023);
    send_block(64'h5555_5555_5555_5555, 10'd512);
    send_block(64'hAAAA_AAAA_AAAA_AAAA, 10'd513);

    // range edges, close while closed, open while open, segment after close
    apply_setting('1, 64'h1000, 64'h2000, 64'h3, 64'h4000, 64'h5000);
    send_block(64'h0FFF, 10'd7);
    send_block(64'h1000, 10'd9);
    send_block(64'h1FFF, 10'd11);
    send_block(64'h2000, 10'd13);
    send_block(64'h5000, 10'd5);
    send_block(64'h4000, 10'd3);
    send_block(64'h1800, 10'd100);
    send_block(64'h3000, 10'd1023);
    send_block(64'h4000, 10'd2);
    send_block(64'h9000, 10'd50);
    send_block(64'h5000, 10'd4);
    send_block(64'h9000, 10'd60);
    send_block(64'h5000, 10'd0);

    // empty range and a shared open/close address
    apply_setting(64'h8000_0000_0000_0001, 64'h8000, 64'h8000, 64'h1, 64'h7000, 64'h7000);
    send_block(64'h8000, 10'd20);
    send_block(64'h7000, 10'd6);
    send_block(64'h7100, 10'd30);

    // enables written with bit 0 clear: markers become ordinary blocks
    apply_setting(64'hFFFF_FFFF_FFFF_FFFE, 64'h9000, 64'h0100, 64'h2, 64'h7000, 64'h7100);
    send_block(64'h7100, 10'd8);
    send_block(64'h7000, 10'd8);
    send_block(64'h0050, 10'd1);

    for (int p = 0; p < RANDOM_PHASES; p++) run_random_phase(p);

    wait_idle();
    if (mismatch_count == 0 && results_owed == 0)
      $display("gated_instruction_counter_top test passed");
    else
      $display("gated_instruction_counter_top test failed");
    $finish;
  end

endmodule
